// File: hw/rtl/linear_probe_key_table_macros.svh
// Assertion macros shared by the linear probe key table RTL.
`ifndef LINEAR_PROBE_KEY_TABLE_MACROS_SVH
`define LINEAR_PROBE_KEY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on aclk and silent while aresetn is low.
`define LPKT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lpkt same-cycle check failed");

// Next-cycle implication, sampled on aclk and silent while aresetn is low.
`define LPKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lpkt next-cycle check failed");

`endif

// File: hw/rtl/lpkt_pkg.sv
// Types and constants of the linear probe key table.
package lpkt_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W     = 9;
    localparam int KEY_W     = 32;
    localparam int FLAGS_W   = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_OUT_W = 8;
    localparam int TOMB_BIT  = 15;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(60);

    // Remainder unit: bits of the key consumed per cycle.
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = KEY_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] flags;
        logic [DATA_W-1:0]  data;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_EV   = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

endpackage

// File: hw/rtl/linear_probe_key_table.sv
// Linear probe key table: open-addressing store of keyed entries with its sequencer.
//
// Usage: a request word enters on the s_ channel (s_tuser carries the request
// kind, s_tdata the key, flags and data) and one result word leaves on the m_
// channel (m_tuser carries the status, m_tdata the flags, data and slot).
// The table size register is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Stored entries are kept when it changes. A clear request answers in the cycle
// after acceptance. Every other request first reduces the key modulo the
// effective table size in a shared 4-bit-per-cycle remainder unit, then walks
// the probe chain one slot at a time (memory read, then evaluate); at most as many
// slots as the effective table size are probed before table full is reported.
// One request is in flight at a time: s_tready is high only when the block is
// idle, and it stays low while a result waits for m_tready, so a stalled
// receiver simply holds the block. Synchronous reset (aresetn low) empties the
// table at once through per-slot valid bits and sets the table size to 60.
`include "linear_probe_key_table_macros.svh"

module linear_probe_key_table
    import lpkt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [31:0] key, [47:32] entry_flags, [79:48] entry_data
    input  logic [79:0]       s_tdata,
    // [1:0] req_type
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [15:0] found_flags, [47:16] found_data, [55:48] slot_index
    output logic [55:0]       m_tdata,
    // [1:0] status
    output logic [1:0]        m_tuser
);

    // Configuration and the effective slot count derived from it.
    logic [CFG_W-1:0]  table_size_reg;
    logic [SIZE_W-1:0] eff_size;

    // Sequencer and request context.
    state_t                 state_reg, state_next;
    logic [1:0]             req_reg;
    logic                   stop_any_reg;
    entry_t                 req_entry_reg;

    // Remainder unit.
    logic [KEY_W-1:0]       dividend_reg;
    logic [SIZE_W-1:0]      rem_reg;
    logic [SIZE_W-1:0]      rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;

    // Probe walk.
    logic [SLOT_W-1:0]      idx_reg;
    logic [SIZE_W-1:0]      probe_cnt_reg;
    logic [SIZE_W-1:0]      idx_inc;
    logic [SIZE_W-1:0]      cnt_inc;

    // Slot storage: valid bits in flops, entries in a memory.
    logic [MAX_SLOTS-1:0]   slot_valid_reg;
    entry_t                 slot_mem [MAX_SLOTS];
    entry_t                 rd_entry_reg;
    logic                   mem_we;
    entry_t                 mem_wdata;

    // Result register.
    logic [1:0]             status_reg;
    logic [FLAGS_W-1:0]     out_flags_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic [SLOT_W-1:0]      out_slot_reg;

    logic                   in_fire;
    logic                   out_fire;
    logic                   cur_valid;
    logic                   probe_stop;
    logic                   live_match;
    logic [FLAGS_W-1:0]     tomb_flags;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = status_reg;
    assign m_tdata  = {IDX_OUT_W'(out_slot_reg), out_data_reg, out_flags_reg};

    // A size of zero acts as one; anything above the storage acts as the storage.
    always_comb begin
        if (table_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (int'(table_size_reg) > MAX_SLOTS) begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end else begin
            eff_size = SIZE_W'(table_size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            table_size_reg <= cfg_wr_data;
        end
    end

    // Restoring remainder, several key bits per cycle. The partial remainder
    // always stays below the divisor, so one compare and subtract per bit does.
    always_comb begin
        logic [SIZE_W:0] trial;
        logic [SIZE_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++) begin
            trial = {r, dividend_reg[KEY_W-1-i]};
            if (trial >= {1'b0, eff_size}) begin
                trial = trial - {1'b0, eff_size};
            end
            r = trial[SIZE_W-1:0];
        end
        rem_next = r;
    end

    // Probe evaluation on the slot read in the previous cycle.
    assign cur_valid  = slot_valid_reg[idx_reg];
    assign probe_stop = !cur_valid || stop_any_reg || (rd_entry_reg.key == req_entry_reg.key);
    assign live_match = cur_valid && !rd_entry_reg.flags[TOMB_BIT];
    assign tomb_flags = rd_entry_reg.flags | (FLAGS_W'(1) << TOMB_BIT);
    assign idx_inc    = SIZE_W'(idx_reg) + SIZE_W'(1);
    assign cnt_inc    = probe_cnt_reg + SIZE_W'(1);

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_wdata  = req_entry_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = (s_tuser == REQ_CLEAR) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                if (probe_stop) begin
                    state_next = S_OUT;
                    if (req_reg == REQ_INSERT) begin
                        mem_we = 1'b1;
                    end else if (req_reg == REQ_DELETE && live_match) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{key: rd_entry_reg.key, flags: tomb_flags,
                                      data: rd_entry_reg.data};
                    end
                end else if (cnt_inc == eff_size) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_RD;
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Valid bits: reset and clear empty the whole table at once; an insert sets the bit of its slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else if (in_fire && s_tuser == REQ_CLEAR) begin
            slot_valid_reg <= '0;
        end else if (state_reg == S_EV && probe_stop && req_reg == REQ_INSERT) begin
            slot_valid_reg[idx_reg] <= 1'b1;
        end
    end

    // Entry memory: one write port, one registered read port at the probe index.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[idx_reg] <= mem_wdata;
        end
        rd_entry_reg <= slot_mem[idx_reg];
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg   <= '0;
            probe_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    div_cnt_reg   <= '0;
                    probe_cnt_reg <= '0;
                end
                S_DIV: begin
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                end
                S_EV: begin
                    probe_cnt_reg <= cnt_inc;
                end
                default: begin
                    div_cnt_reg <= div_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    req_reg             <= s_tuser;
                    req_entry_reg.key   <= s_tdata[31:0];
                    req_entry_reg.flags <= s_tdata[47:32];
                    req_entry_reg.data  <= s_tdata[79:48];
                    stop_any_reg        <= (s_tuser == REQ_INSERT) && s_tdata[32 + TOMB_BIT];
                    dividend_reg        <= s_tdata[31:0];
                    rem_reg             <= '0;
                    status_reg          <= STATUS_OK;
                    out_flags_reg       <= '0;
                    out_data_reg        <= '0;
                    out_slot_reg        <= '0;
                end
            end
            S_DIV: begin
                rem_reg      <= rem_next;
                dividend_reg <= dividend_reg << DIV_STEPS;
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    idx_reg <= rem_next[SLOT_W-1:0];
                end
            end
            S_EV: begin
                if (probe_stop) begin
                    if (req_reg == REQ_INSERT) begin
                        status_reg   <= STATUS_OK;
                        out_slot_reg <= idx_reg;
                    end else if (live_match) begin
                        status_reg    <= STATUS_OK;
                        out_flags_reg <= (req_reg == REQ_DELETE) ? tomb_flags
                                                                 : rd_entry_reg.flags;
                        out_data_reg  <= rd_entry_reg.data;
                        out_slot_reg  <= idx_reg;
                    end else begin
                        status_reg <= STATUS_MISS;
                    end
                end else if (cnt_inc == eff_size) begin
                    status_reg <= STATUS_FULL;
                end else begin
                    idx_reg <= (idx_inc == eff_size) ? '0 : idx_inc[SLOT_W-1:0];
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Checks on the sequencer and the probe walk.
    `LPKT_ASSERT_NOW(a_one_in_flight, m_tvalid, !s_tready)
    `LPKT_ASSERT_NEXT(a_clear_answers_next, in_fire && s_tuser == REQ_CLEAR,
                      m_tvalid && m_tuser == STATUS_OK && m_tdata == '0)
    `LPKT_ASSERT_NOW(a_probe_in_range, state_reg == S_RD || state_reg == S_EV,
                     SIZE_W'(idx_reg) < eff_size && probe_cnt_reg < eff_size)
    `LPKT_ASSERT_NEXT(a_full_has_no_payload, state_reg == S_EV && state_next == S_OUT
                      && !probe_stop, m_tdata == '0)

endmodule

// File: sim/lpkt_tb_pkg.sv
// Request and result words of the key table, and a shadow copy of the table that predicts results.
package lpkt_tb_pkg;

    import lpkt_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] flags;
        logic [DATA_W-1:0]  data;
    } request_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [FLAGS_W-1:0]   flags;
        logic [DATA_W-1:0]    data;
        logic [IDX_OUT_W-1:0] slot;
    } result_t;

    class table_shadow;
        bit                 slot_live  [MAX_SLOTS];
        logic [KEY_W-1:0]   slot_key   [MAX_SLOTS];
        logic [FLAGS_W-1:0] slot_flags [MAX_SLOTS];
        logic [DATA_W-1:0]  slot_data  [MAX_SLOTS];
        logic [CFG_W-1:0]   size_reg;
        result_t            pending_results[$];
        int                 mismatches;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            size_reg   = SIZE_RESET;
            mismatches = 0;
        endfunction

        function void set_size(logic [CFG_W-1:0] value);
            size_reg = value;
        endfunction

        // Number of slots the probe really covers.
        function int span();
            if (size_reg == 0) return 1;
            if (size_reg > MAX_SLOTS) return MAX_SLOTS;
            return int'(size_reg);
        endfunction

        // Returns 1 when some slot ends the walk, with its index in pos.
        function bit walk_chain(logic [KEY_W-1:0] key, bit stop_any, output int pos);
            int n_slots;
            int idx;
            int n;
            n_slots = span();
            idx     = int'(key % KEY_W'(n_slots));
            pos     = 0;
            for (n = 0; n < n_slots; n++) begin
                if (!slot_live[idx] || stop_any || slot_key[idx] == key) begin
                    pos = idx;
                    return 1'b1;
                end
                idx = (idx + 1 == n_slots) ? 0 : idx + 1;
            end
            return 1'b0;
        endfunction

        function void accept_request(request_t req);
            result_t res;
            int      pos;
            res = '0;
            res.status = STATUS_OK;
            case (req.kind)
                REQ_CLEAR: begin
                    foreach (slot_live[i]) slot_live[i] = 1'b0;
                end
                REQ_INSERT: begin
                    if (walk_chain(req.key, req.flags[TOMB_BIT], pos)) begin
                        slot_live[pos]  = 1'b1;
                        slot_key[pos]   = req.key;
                        slot_flags[pos] = req.flags;
                        slot_data[pos]  = req.data;
                        res.slot        = IDX_OUT_W'(pos);
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
                default: begin
                    if (!walk_chain(req.key, 1'b0, pos)) begin
                        res.status = STATUS_FULL;
                    end else if (!slot_live[pos] || slot_flags[pos][TOMB_BIT]) begin
                        res.status = STATUS_MISS;
                    end else begin
                        if (req.kind == REQ_DELETE) slot_flags[pos][TOMB_BIT] = 1'b1;
                        res.flags = slot_flags[pos];
                        res.data  = slot_data[pos];
                        res.slot  = IDX_OUT_W'(pos);
                    end
                end
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d flags %h data %h slot %0d",
                             got.status, got.flags, got.data, got.slot);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.flags !== want.flags ||
                got.data !== want.data || got.slot !== want.slot) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected status %0d flags %h data %h slot %0d, %s",
                             want.status, want.flags, want.data, want.slot,
                             $sformatf("got status %0d flags %h data %h slot %0d",
                                       got.status, got.flags, got.data, got.slot));
            end
        endfunction

        function bit failed();
            return mismatches != 0 || pending_results.size() != 0;
        endfunction
    endclass

endpackage

// File: sim/tb.sv
// Self-checking bench of the linear probe key table: directed and random request streams.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpkt_pkg::*;
    import lpkt_tb_pkg::*;

    // The wait for a straggler result is sized from a full-table probe at the
    // largest size.
    localparam int  DRAIN_CYCLES = 600;
    // The limit leaves a wide margin over the slowest correct run, even if every
    // request walked the whole table.
    localparam int  LIMIT_CYCLES = 2_000_000;
    localparam int  SEGMENTS     = 13;
    localparam int  SEG_ITEMS    = 50;
    localparam int  POOL_KEYS    = 12;
    localparam int  HOLD_CYCLES  = 400;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    // [31:0] key, [47:32] entry_flags, [79:48] entry_data
    logic [79:0]       s_tdata;
    // [1:0] req_type
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // [15:0] found_flags, [47:16] found_data, [55:48] slot_index
    logic [55:0]       m_tdata;
    // [1:0] status
    logic [1:0]        m_tuser;

    // Percent of cycles in which each side holds back, and a running count of
    // requests for a long refusal by the receiver.
    int                tx_idle_pct   = 14;
    int                rx_idle_pct   = 77;
    int                hold_requests = 0;
    int                cycle_count   = 0;

    table_shadow       shadow = new();

    linear_probe_key_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Receiver side: ready changes only at the falling edge. A new hold
    // request keeps it low for a long stretch, counted here and nowhere else.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Every result word taken at a rising edge goes straight to the shadow
    // table, which compares it with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            shadow.check_result({m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[55:48]});
    end

    // Watchdog: a run that never drains ends here as a failure.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offers one request word. Valid is left high after the handshake so
    // that back-to-back words never see valid dropped and raised in one step;
    // the next call or a quiet period decides what happens to it.
    task automatic send_word(input request_t req);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {req.data, req.flags, req.key};
        s_tuser  = req.kind;
        do @(posedge aclk); while (s_tready !== 1'b1);
        shadow.accept_request(req);
    endtask

    task automatic issue(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                         input logic [FLAGS_W-1:0] flags, input logic [DATA_W-1:0] data);
        send_word('{kind, key, flags, data});
    endtask

    // Lets the table finish every request in flight, then changes its size.
    // The register only moves while the block sits idle.
    task automatic write_table_size(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        shadow.set_size(value);
    endtask

    // Random traffic at one table size. Most keys come from a small pool,
    // half of which share a home slot, so chains collide, hits and deletes
    // find live entries, and small tables fill up and report full.
    task automatic random_segment(input logic [CFG_W-1:0] size_val, input int count,
                                  input bit long_hold);
        logic [KEY_W-1:0] key_pool [POOL_KEYS];
        logic [KEY_W-1:0] home;
        logic [KEY_W-1:0] n_slots;
        request_t         req;
        int               roll;
        write_table_size(size_val);
        // The long refusal starts only once the size is set, so words keep
        // coming while the block holds its result and stops taking input.
        if (long_hold) hold_requests++;
        n_slots = (size_val == 0) ? 1 : (size_val > MAX_SLOTS) ? MAX_SLOTS : KEY_W'(size_val);
        home    = $urandom % n_slots;
        foreach (key_pool[i])
            key_pool[i] = (i < POOL_KEYS / 2) ? $urandom_range(4000) * n_slots + home : $urandom;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 42)      req.kind = REQ_INSERT;
            else if (roll < 72) req.kind = REQ_LOOKUP;
            else if (roll < 95) req.kind = REQ_DELETE;
            else                req.kind = REQ_CLEAR;
            req.key   = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                                  : $urandom;
            req.flags = FLAGS_W'($urandom);
            // Inserts that carry the deleted flag overwrite whatever they
            // meet first, so keep them to a minority.
            if ($urandom_range(99) < 85) req.flags[TOMB_BIT] = 1'b0;
            req.data  = $urandom;
            send_word(req);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] seg_sizes [SEGMENTS - 1] = '{
            9'd2, 9'd7, 9'd60, 9'd256, 9'd3, 9'd300,
            9'd16, 9'd1, 9'd511, 9'd255, 9'd0, 9'd37
        };
        logic [CFG_W-1:0] size_val;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_INSERT;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words at the reset size of 60 slots: a miss on the empty
        // table, the widest key, a collision that moves to the next slot, a
        // replacement of a same-key entry, a miss that walks past live slots,
        // delete and its tombstone, and a deleted-flag insert that takes an
        // occupied slot regardless of its key.
        issue(REQ_LOOKUP, 32'd0,          16'h0000, 32'h0000_0000);
        issue(REQ_INSERT, 32'd0,          16'h0000, 32'h0000_0000);
        issue(REQ_INSERT, 32'hFFFF_FFFF,  16'h7FFF, 32'hFFFF_FFFF);
        issue(REQ_INSERT, 32'd60,         16'h0001, 32'hA5A5_5A5A);
        issue(REQ_INSERT, 32'd0,          16'h0002, 32'h1234_5678);
        issue(REQ_LOOKUP, 32'd60,         16'h0000, 32'h0000_0000);
        issue(REQ_LOOKUP, 32'd120,        16'hFFFF, 32'hFFFF_FFFF);
        issue(REQ_DELETE, 32'd60,         16'h0000, 32'h0000_0000);
        issue(REQ_LOOKUP, 32'd60,         16'h0000, 32'h0000_0000);
        issue(REQ_DELETE, 32'd60,         16'h0000, 32'h0000_0000);
        issue(REQ_INSERT, 32'd1,          16'h8000, 32'hDEAD_BEEF);
        issue(REQ_LOOKUP, 32'hFFFF_FFFF,  16'h0000, 32'h0000_0000);
        issue(REQ_CLEAR,  32'hFFFF_FFFF,  16'hFFFF, 32'hFFFF_FFFF);
        issue(REQ_LOOKUP, 32'd0,          16'h0000, 32'h0000_0000);

        // A size of zero acts as one slot: the second key finds the table
        // full for insert and lookup alike.
        write_table_size(9'd0);
        issue(REQ_INSERT, 32'd7,          16'h0010, 32'h0000_0007);
        issue(REQ_INSERT, 32'd8,          16'h0020, 32'h0000_0008);
        issue(REQ_LOOKUP, 32'd8,          16'h0000, 32'h0000_0000);
        issue(REQ_DELETE, 32'd7,          16'h0000, 32'h0000_0000);
        issue(REQ_INSERT, 32'd8,          16'hFFFF, 32'h8888_8888);

        // Two slots, both filled, then a third key probes the full cycle.
        write_table_size(9'd2);
        issue(REQ_CLEAR,  32'd0,          16'h0000, 32'h0000_0000);
        issue(REQ_INSERT, 32'd2,          16'h0002, 32'h0000_0002);
        issue(REQ_INSERT, 32'd4,          16'h0004, 32'h0000_0004);
        issue(REQ_INSERT, 32'd6,          16'h0006, 32'h0000_0006);
        issue(REQ_LOOKUP, 32'd8,          16'h0000, 32'h0000_0000);

        // A size above the slot count is used as the full table. Old entries
        // stay, so a probe from the top slot wraps into them.
        write_table_size(9'd257);
        issue(REQ_INSERT, 32'd255,        16'h0FF0, 32'h0000_00FF);
        issue(REQ_LOOKUP, 32'd511,        16'h0000, 32'h0000_0000);

        // Random segments, each at its own table size. The first block of
        // segments has a slow receiver, the next a slow sender, and the
        // last runs with neither side idling.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 5) begin
                tx_idle_pct = 77;
                rx_idle_pct = 14;
            end else if (seg == 9) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            size_val = (seg == SEGMENTS - 1) ? CFG_W'($urandom_range(511)) : seg_sizes[seg];
            // One long refusal by the receiver while words keep coming: the
            // block holds its result and stops taking input.
            random_segment(size_val, SEG_ITEMS, seg == 5);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.failed())
            $display("FAIL");
        else
            $display("PASS");
        $finish;
    end

endmodule
